@@ sv/lcd_pkg.sv @@
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared types and constants of the 3D label contact detector.
// ----------------------------------------------------------------------------
package lcd_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;
  localparam int DEF_LABEL_BITS = 24;

  localparam int MAX_DEPTH      = 1024;
  localparam int DEPTH_BITS     = 11;
  localparam int LABEL_W        = 24;
  localparam int INDEX_W        = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;
  localparam int CMD_FIFO_DEPTH = 4;

  localparam int FLAG_W = 3;
  localparam int FLAG_A = 0;
  localparam int FLAG_B = 1;
  localparam int FLAG_M = 2;

  typedef enum logic {
    OP_VOXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LABEL_A    = 3'd0,
    REG_LABEL_B    = 3'd1,
    REG_VOL_WIDTH  = 3'd2,
    REG_VOL_HEIGHT = 3'd3,
    REG_VOL_DEPTH  = 3'd4,
    REG_USE_MASK   = 3'd5
  } cfg_reg_e;

  typedef logic [FLAG_W-1:0] flags_t;

  typedef struct packed {
    logic   has_data;
    flags_t flags;
    logic   emit;
  } cmd_t;

endpackage

@@ sv/lcd_ram.sv @@
// ----------------------------------------------------------------------------
// lcd_ram
// Generic single-port RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module lcd_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[addr_i];
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/lcd_delay.sv @@
// ----------------------------------------------------------------------------
// lcd_delay
// Run-time length delay line over a ring buffer, advancing on each step.
// ----------------------------------------------------------------------------
module lcd_delay #(
  parameter int WIDTH    = 3,
  parameter int MAX_LEN  = 128,
  localparam int LEN_BITS = $clog2(MAX_LEN + 1),
  localparam int AW       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clr_i,
  input  logic                step_i,
  input  logic [LEN_BITS-1:0] len_i,
  input  logic [WIDTH-1:0]    din_i,
  output logic [WIDTH-1:0]    dout_o
);

  logic [AW-1:0]    ptr_q, ptr_d;
  logic [WIDTH-1:0] short_q;
  logic [WIDTH-1:0] ram_rd;
  logic             wrap;

  // ring of len-1 entries plus the read register gives len steps
  assign wrap  = ((LEN_BITS+1)'(ptr_q) + (LEN_BITS+1)'(2)) >= (LEN_BITS+1)'(len_i);
  assign ptr_d = wrap ? '0 : ptr_q + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (clr_i) begin
      ptr_q <= '0;
    end else if (step_i) begin
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      short_q <= din_i;
    end
  end

  lcd_ram #(
    .WIDTH (WIDTH),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (step_i),
    .we_i    (step_i),
    .addr_i  (ptr_q),
    .wdata_i (din_i),
    .rdata_o (ram_rd)
  );

  assign dout_o = (len_i == LEN_BITS'(1)) ? short_q : ram_rd;

endmodule

@@ sv/lcd_fifo.sv @@
// ----------------------------------------------------------------------------
// lcd_fifo
// Small command queue between the classifier and the window engine.
// ----------------------------------------------------------------------------
module lcd_fifo
  import lcd_pkg::*;
#(
  parameter int DEPTH = CMD_FIFO_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ sv/lcd_front.sv @@
// ----------------------------------------------------------------------------
// lcd_front
// Configuration registers, volume geometry and item classification.
// ----------------------------------------------------------------------------
module lcd_front
  import lcd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int LABEL_BITS = DEF_LABEL_BITS,
  localparam int WB  = $clog2(MAX_WIDTH + 1),
  localparam int HB  = $clog2(MAX_HEIGHT + 1),
  localparam int PB  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  localparam int LB  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2),
  localparam int VB  = $clog2(longint'(MAX_WIDTH) * longint'(MAX_HEIGHT)
                              * longint'(MAX_DEPTH) + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_op_i,
  input  logic [LABEL_W-1:0]    in_label_i,
  input  logic                  in_mask_i,
  output logic                  cmd_push_o,
  output cmd_t                  cmd_o,
  input  logic                  fifo_full_i,
  output logic [WB-1:0]         dim_w_o,
  output logic [HB-1:0]         dim_h_o,
  output logic [DEPTH_BITS-1:0] dim_d_o,
  output logic [PB-1:0]         plane_o,
  output logic [LB-1:0]         lag_o,
  output logic                  use_mask_o,
  output logic                  restart_o
);

  localparam int CMP = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;

  logic [LABEL_W-1:0]    label_a_q, label_b_q;
  logic [7:0]            width_q, height_q;
  logic [DEPTH_BITS-1:0] depth_q;
  logic                  use_mask_q;
  logic [2:0]            settle_q;

  logic [WB-1:0]         w_d, w_q;
  logic [HB-1:0]         h_d, h_q;
  logic [DEPTH_BITS-1:0] d_d, d_q;
  logic [PB-1:0]         plane_q;
  logic [VB-1:0]         volume_q, vol_m1_q;
  logic [LB-1:0]         lag_q;
  logic [WB+HB-1:0]      plane_full;
  logic [PB+DEPTH_BITS-1:0] vol_full;

  logic [VB-1:0] acc_q, out_q, acc_n;
  logic [VB:0]   out_lag;
  logic          cfg_we, accept, is_voxel, emit, last;
  cfg_reg_e      reg_sel;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign reg_sel     = cfg_reg_e'(cfg_index_i);
  assign restart_o   = cfg_we && (reg_sel == REG_VOL_WIDTH || reg_sel == REG_VOL_HEIGHT
                                  || reg_sel == REG_VOL_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_a_q  <= '0;
      label_b_q  <= LABEL_W'(1);
      width_q    <= 8'd128;
      height_q   <= 8'd128;
      depth_q    <= DEPTH_BITS'(1);
      use_mask_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_LABEL_A:    label_a_q  <= cfg_data_i[LABEL_W-1:0];
        REG_LABEL_B:    label_b_q  <= cfg_data_i[LABEL_W-1:0];
        REG_VOL_WIDTH:  width_q    <= cfg_data_i[7:0];
        REG_VOL_HEIGHT: height_q   <= cfg_data_i[7:0];
        REG_VOL_DEPTH:  depth_q    <= cfg_data_i[DEPTH_BITS-1:0];
        REG_USE_MASK:   use_mask_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  always_comb begin
    if (width_q == 8'd0) begin
      w_d = WB'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_d = WB'(MAX_WIDTH);
    end else begin
      w_d = WB'(width_q);
    end
    if (height_q == 8'd0) begin
      h_d = HB'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      h_d = HB'(MAX_HEIGHT);
    end else begin
      h_d = HB'(height_q);
    end
    if (depth_q == '0) begin
      d_d = DEPTH_BITS'(1);
    end else if (int'(depth_q) > MAX_DEPTH) begin
      d_d = DEPTH_BITS'(MAX_DEPTH);
    end else begin
      d_d = depth_q;
    end
  end

  assign plane_full = {HB'(0), w_q} * {WB'(0), h_q};
  assign vol_full   = {DEPTH_BITS'(0), plane_q} * {PB'(0), d_q};

  // geometry pipeline: clamped sizes, then plane size, then volume and lag, then volume minus one
  always_ff @(posedge clk_i) begin
    w_q      <= w_d;
    h_q      <= h_d;
    d_q      <= d_d;
    plane_q  <= PB'(plane_full);
    volume_q <= VB'(vol_full);
    lag_q    <= LB'(plane_q) + LB'(w_q) + LB'(1);
    vol_m1_q <= volume_q - VB'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 3'd4;
    end else if (cfg_we) begin
      settle_q <= 3'd4;
    end else if (settle_q != 3'd0) begin
      settle_q <= settle_q - 3'd1;
    end
  end

  assign in_ready_o = !fifo_full_i && (settle_q == 3'd0);
  assign accept     = in_valid_i && in_ready_o;

  assign is_voxel = (op_e'(in_op_i) == OP_VOXEL) && (acc_q < volume_q);
  assign acc_n    = acc_q + VB'(is_voxel);
  assign out_lag  = (VB+1)'(out_q) + (VB+1)'(lag_q);
  assign emit     = (out_q < acc_n)
                    && ((acc_n >= volume_q) || ((VB+1)'(acc_n) > out_lag));
  assign last     = emit && (out_q == vol_m1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      out_q <= '0;
    end else if (restart_o) begin
      acc_q <= '0;
      out_q <= '0;
    end else if (accept) begin
      if (last) begin
        acc_q <= '0;
        out_q <= '0;
      end else begin
        acc_q <= acc_n;
        out_q <= out_q + VB'(emit);
      end
    end
  end

  assign cmd_push_o            = accept && (is_voxel || emit);
  assign cmd_o.has_data        = is_voxel;
  assign cmd_o.emit            = emit;
  assign cmd_o.flags[FLAG_A]   = (in_label_i[CMP-1:0] == label_a_q[CMP-1:0]);
  assign cmd_o.flags[FLAG_B]   = (in_label_i[CMP-1:0] == label_b_q[CMP-1:0]);
  assign cmd_o.flags[FLAG_M]   = in_mask_i;

  assign dim_w_o    = w_q;
  assign dim_h_o    = h_q;
  assign dim_d_o    = d_q;
  assign plane_o    = plane_q;
  assign lag_o      = lag_q;
  assign use_mask_o = use_mask_q;

endmodule

@@ sv/lcd_back.sv @@
// ----------------------------------------------------------------------------
// lcd_back
// 3x3x3 flag window over plane and row delay lines, contact decision.
// ----------------------------------------------------------------------------
module lcd_back
  import lcd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int WB  = $clog2(MAX_WIDTH + 1),
  localparam int HB  = $clog2(MAX_HEIGHT + 1),
  localparam int PB  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  localparam int LB  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2),
  localparam int VB  = $clog2(longint'(MAX_WIDTH) * longint'(MAX_HEIGHT)
                              * longint'(MAX_DEPTH) + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  input  logic [WB-1:0]         dim_w_i,
  input  logic [HB-1:0]         dim_h_i,
  input  logic [DEPTH_BITS-1:0] dim_d_i,
  input  logic [PB-1:0]         plane_i,
  input  logic [LB-1:0]         lag_i,
  input  logic                  use_mask_i,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [INDEX_W-1:0]    out_index_o,
  output logic                  out_in_a_o,
  output logic                  out_in_b_o,
  output logic                  out_contact_a_o,
  output logic                  out_contact_b_o,
  output logic                  out_last_o
);

  flags_t s    [3][3];
  flags_t c1_q [3][3];
  flags_t c2_q [3][3];
  flags_t push_val, center, tap;

  logic [WB-1:0]         x_q;
  logic [HB-1:0]         y_q;
  logic [DEPTH_BITS-1:0] z_q;
  logic [VB-1:0]         pos_q;
  logic [VB+INDEX_W-1:0] pos_ext;
  logic [LB-1:0]         fill_q;
  logic                  done_q, ovalid_q;
  logic                  step, fill_ge, emit_now, consume, last;
  logic                  near_a, near_b, mask_ok;
  logic [2:0]            vx, vy, vz;

  assign push_val  = (cmd_i.has_data && !done_q) ? cmd_i.flags : '0;
  assign fill_ge   = (fill_q >= lag_i);
  assign emit_now  = cmd_i.emit && fill_ge;
  assign step      = cmd_valid_i && (!ovalid_q || out_ready_i);
  assign consume   = !cmd_i.emit || emit_now;
  assign cmd_pop_o = step && consume;

  assign s[0][0] = push_val;

  lcd_delay #(.WIDTH(FLAG_W), .MAX_LEN(MAX_WIDTH * MAX_HEIGHT)) u_plane1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .clr_i (restart_i), .step_i (step),
    .len_i (plane_i), .din_i (s[0][0]), .dout_o (s[1][0])
  );

  lcd_delay #(.WIDTH(FLAG_W), .MAX_LEN(MAX_WIDTH * MAX_HEIGHT)) u_plane2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .clr_i (restart_i), .step_i (step),
    .len_i (plane_i), .din_i (s[1][0]), .dout_o (s[2][0])
  );

  for (genvar k = 0; k < 3; k++) begin : g_plane
    lcd_delay #(.WIDTH(FLAG_W), .MAX_LEN(MAX_WIDTH)) u_row1 (
      .clk_i (clk_i), .rst_ni (rst_ni), .clr_i (restart_i), .step_i (step),
      .len_i (dim_w_i), .din_i (s[k][0]), .dout_o (s[k][1])
    );
    lcd_delay #(.WIDTH(FLAG_W), .MAX_LEN(MAX_WIDTH)) u_row2 (
      .clk_i (clk_i), .rst_ni (rst_ni), .clr_i (restart_i), .step_i (step),
      .len_i (dim_w_i), .din_i (s[k][1]), .dout_o (s[k][2])
    );
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          c1_q[k][j] <= s[k][j];
          c2_q[k][j] <= c1_q[k][j];
        end
      end
    end
  end

  // neighbor bounds; index 0 is the +1 side, 2 the -1 side
  assign vx = {x_q != '0, 1'b1, (x_q + WB'(1)) < dim_w_i};
  assign vy = {y_q != '0, 1'b1, (y_q + HB'(1)) < dim_h_i};
  assign vz = {z_q != '0, 1'b1, (z_q + DEPTH_BITS'(1)) < dim_d_i};

  assign center = c1_q[1][1];

  always_comb begin
    near_a = 1'b0;
    near_b = 1'b0;
    tap    = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          if (i == 0) begin
            tap = s[k][j];
          end else if (i == 1) begin
            tap = c1_q[k][j];
          end else begin
            tap = c2_q[k][j];
          end
          if (!(k == 1 && j == 1 && i == 1) && vz[k] && vy[j] && vx[i]) begin
            near_a = near_a | tap[FLAG_A];
            near_b = near_b | tap[FLAG_B];
          end
        end
      end
    end
  end

  assign mask_ok = !use_mask_i || center[FLAG_M];
  assign last    = ((x_q + WB'(1)) == dim_w_i) && ((y_q + HB'(1)) == dim_h_i)
                   && ((z_q + DEPTH_BITS'(1)) == dim_d_i);
  assign pos_ext = {INDEX_W'(0), pos_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      pos_q  <= '0;
      fill_q <= '0;
      done_q <= 1'b0;
    end else if (restart_i) begin
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      pos_q  <= '0;
      fill_q <= '0;
      done_q <= 1'b0;
    end else if (step) begin
      done_q <= !consume;
      if (emit_now && last) begin
        x_q    <= '0;
        y_q    <= '0;
        z_q    <= '0;
        pos_q  <= '0;
        fill_q <= '0;
      end else begin
        if (!fill_ge) begin
          fill_q <= fill_q + LB'(1);
        end
        if (emit_now) begin
          pos_q <= pos_q + VB'(1);
          if ((x_q + WB'(1)) == dim_w_i) begin
            x_q <= '0;
            if ((y_q + HB'(1)) == dim_h_i) begin
              y_q <= '0;
              z_q <= z_q + DEPTH_BITS'(1);
            end else begin
              y_q <= y_q + HB'(1);
            end
          end else begin
            x_q <= x_q + WB'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (step && emit_now) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit_now) begin
      out_index_o     <= pos_ext[INDEX_W-1:0];
      out_in_a_o      <= center[FLAG_A];
      out_in_b_o      <= center[FLAG_B];
      out_contact_a_o <= center[FLAG_A] && mask_ok && near_b;
      out_contact_b_o <= center[FLAG_B] && mask_ok && near_a;
      out_last_o      <= last;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

@@ sv/label_contact_detection_3d_top.sv @@
// ----------------------------------------------------------------------------
// label_contact_detection_3d_top
// Two-body 26-neighbor contact detector over a raster-ordered label volume.
// ----------------------------------------------------------------------------
// usage:
//   cfg channel writes labels, volume size and mask enable; a size write
//   restarts the stream, and a settle counter holds off input after any write
//   s_axis carries one voxel (tuser = 0) or one drain request (tuser = 1)
//   m_axis carries one result per voxel, tlast on the final voxel
// throughput: one item per cycle while s_axis_tready is high; each voxel
//   transfer releases the result of the voxel W*H+W+1 places earlier, so
//   results trail by that many voxels
// output: results pass the command queue, then the output register
// drains: once the whole volume is in, each drain releases one pending
//   result; when the volume holds at most W*H+W+1 voxels the last voxel
//   first flushes the plane and row delay lines with the command queue stalled
// reset: sizes 128x128x1, label_a 0, label_b 1, mask off, stream empty
// stall: m_axis backpressure holds the window; a 4-entry command queue keeps
//   s_axis accepting until it fills
// ----------------------------------------------------------------------------
module label_contact_detection_3d_top
  import lcd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int LABEL_BITS = DEF_LABEL_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,  // voxel_label, mask_bit, zero pad
  input  logic [0:0]            s_axis_tuser,  // operation
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,  // voxel_index, in_body_a, in_body_b,
                                               // contact_a, contact_b, zero pad
  output logic                  m_axis_tlast   // last_voxel
);

  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int PB = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LB = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);

  logic                  cmd_push, cmd_pop, fifo_full, fifo_valid;
  cmd_t                  cmd_in, cmd_out;
  logic [WB-1:0]         dim_w;
  logic [HB-1:0]         dim_h;
  logic [DEPTH_BITS-1:0] dim_d;
  logic [PB-1:0]         plane;
  logic [LB-1:0]         lag;
  logic                  use_mask, restart;
  logic [INDEX_W-1:0]    out_index;
  logic                  out_in_a, out_in_b, out_ca, out_cb;

  lcd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .LABEL_BITS (LABEL_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser[0]),
    .in_label_i  (s_axis_tdata[LABEL_W-1:0]),
    .in_mask_i   (s_axis_tdata[LABEL_W]),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .fifo_full_i (fifo_full),
    .dim_w_o     (dim_w),
    .dim_h_o     (dim_h),
    .dim_d_o     (dim_d),
    .plane_o     (plane),
    .lag_o       (lag),
    .use_mask_o  (use_mask),
    .restart_o   (restart)
  );

  lcd_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (fifo_full),
    .pop_i   (cmd_pop),
    .valid_o (fifo_valid),
    .data_o  (cmd_out)
  );

  lcd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (fifo_valid),
    .cmd_i           (cmd_out),
    .cmd_pop_o       (cmd_pop),
    .dim_w_i         (dim_w),
    .dim_h_i         (dim_h),
    .dim_d_i         (dim_d),
    .plane_i         (plane),
    .lag_i           (lag),
    .use_mask_i      (use_mask),
    .restart_i       (restart),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_index_o     (out_index),
    .out_in_a_o      (out_in_a),
    .out_in_b_o      (out_in_b),
    .out_contact_a_o (out_ca),
    .out_contact_b_o (out_cb),
    .out_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_cb, out_ca, out_in_b, out_in_a, out_index};

  a_cfg_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !s_axis_tready)
    else $error("input accepted right after a configuration write");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !fifo_full)
    else $error("command queue overflow");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> fifo_valid)
    else $error("command queue underflow");

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3D two-body contact detector. Streams labelled
// volumes of many sizes, predicts every result in a local model of the
// window and compares each m_axis transfer field by field.
// ----------------------------------------------------------------------------
module tb;
  import lcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_SIZE = 2 * 128 * 128 + 2 * 128 + 3;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic               a;
    logic               b;
    logic               ca;
    logic               cb;
    logic               last;
  } contact_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata = '0;   // voxel_label, mask_bit, zero pad
  logic [0:0]            s_axis_tuser = '0;   // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;        // voxel_index, in_body_a, in_body_b,
                                              // contact_a, contact_b, zero pad
  logic                  m_axis_tlast;        // last_voxel

  label_contact_detection_3d_top dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [23:0]  lab_a = 24'd0, lab_b = 24'd1;
  logic [7:0]   raw_w = 8'd128, raw_h = 8'd128;
  logic [10:0]  raw_d = 11'd1;
  logic         mask_on = 1'b0;
  logic [2:0]   flag_win [WIN_SIZE];
  int           voxels_in = 0;
  int           next_out = 0;
  contact_res_t expected_q[$];
  int           errors = 0;
  int           burst_left = 0;
  int           rx_mode = 0;
  int           hold_cnt = 0;
  int           items_sent = 0;

  function automatic int dim_w();
    return (raw_w == 0) ? 1 : (raw_w > 128) ? 128 : int'(raw_w);
  endfunction
  function automatic int dim_h();
    return (raw_h == 0) ? 1 : (raw_h > 128) ? 128 : int'(raw_h);
  endfunction
  function automatic int dim_d();
    return (raw_d == 0) ? 1 : (raw_d > 1024) ? 1024 : int'(raw_d);
  endfunction
  function automatic int cur_lag();
    return dim_w() * dim_h() + dim_w() + 1;
  endfunction

  task automatic predict_contact(op_e op, logic [23:0] lab, logic m);
    int w, h, d, plane, vol, lag, p, x, y, z, nx, ny, nz;
    logic [2:0] self_f, nf;
    logic near_a, near_b, ok;
    contact_res_t r;
    w = dim_w(); h = dim_h(); d = dim_d();
    plane = w * h; vol = plane * d; lag = plane + w + 1;
    if (op == OP_VOXEL && voxels_in < vol) begin
      flag_win[voxels_in % WIN_SIZE] = {m, lab == lab_b, lab == lab_a};
      voxels_in++;
    end
    if (!(next_out < voxels_in && (voxels_in >= vol || voxels_in > next_out + lag))) return;
    p = next_out;
    x = p % w; y = (p / w) % h; z = p / plane;
    self_f = flag_win[p % WIN_SIZE];
    near_a = 0; near_b = 0;
    for (int dz = -1; dz <= 1; dz++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++) begin
          nx = x + dx; ny = y + dy; nz = z + dz;
          if (dx == 0 && dy == 0 && dz == 0) continue;
          if (nx < 0 || ny < 0 || nz < 0 || nx >= w || ny >= h || nz >= d) continue;
          nf = flag_win[(nz * plane + ny * w + nx) % WIN_SIZE];
          if (nf[FLAG_A]) near_a = 1;
          if (nf[FLAG_B]) near_b = 1;
        end
    ok = !mask_on || self_f[FLAG_M];
    r.idx  = p[23:0];
    r.a    = self_f[FLAG_A];
    r.b    = self_f[FLAG_B];
    r.ca   = self_f[FLAG_A] && ok && near_b;
    r.cb   = self_f[FLAG_B] && ok && near_a;
    r.last = (p == vol - 1);
    expected_q.insert(expected_q.size(), r);
    next_out++;
    if (r.last) begin
      voxels_in = 0;
      next_out = 0;
    end
  endtask

  // all drives happen at the falling edge
  task automatic write_reg(cfg_reg_e idx, logic [23:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_LABEL_A:    lab_a = val;
      REG_LABEL_B:    lab_b = val;
      REG_VOL_WIDTH:  begin raw_w = val[7:0]; voxels_in = 0; next_out = 0; end
      REG_VOL_HEIGHT: begin raw_h = val[7:0]; voxels_in = 0; next_out = 0; end
      REG_VOL_DEPTH:  begin raw_d = val[10:0]; voxels_in = 0; next_out = 0; end
      REG_USE_MASK:   mask_on = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_item(op_e op, logic [23:0] lab, logic m);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'd0, m, lab};
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_contact(op, lab, m);
    items_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic settle();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (cur_lag() + 20) @(negedge clk_i);
  endtask

  task automatic set_volume(logic [7:0] w, logic [7:0] h, logic [10:0] d);
    write_reg(REG_VOL_WIDTH, {16'd0, w});
    write_reg(REG_VOL_HEIGHT, {16'd0, h});
    write_reg(REG_VOL_DEPTH, {13'd0, d});
  endtask

  function automatic logic [23:0] pick_label();
    case ($urandom_range(0, 4))
      0, 1: return lab_a;
      2, 3: return lab_b;
      default: return 24'($urandom());
    endcase
  endfunction

  // one full volume with random content, optional noise, then drains
  task automatic stream_volume(int noise_pct);
    int vol;
    vol = dim_w() * dim_h() * dim_d();
    for (int i = 0; i < vol; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(OP_DRAIN, 24'($urandom()), 1'($urandom()));
      send_item(OP_VOXEL, pick_label(), 1'($urandom()));
    end
    if ($urandom_range(0, 99) < noise_pct)
      send_item(OP_VOXEL, pick_label(), 1'($urandom()));
    while (voxels_in != 0)
      send_item(OP_DRAIN, 24'($urandom()), 1'($urandom()));
  endtask

  task automatic test_directed();
    write_reg(REG_LABEL_A, 24'hFFFFFF);
    write_reg(REG_LABEL_B, 24'h000000);
    write_reg(REG_USE_MASK, 24'd0);
    set_volume(8'd3, 8'd2, 11'd2);
    // early drain, extremes of labels, a non-body voxel
    send_item(OP_DRAIN, 24'hFFFFFF, 1'b1);
    send_item(OP_VOXEL, 24'hFFFFFF, 1'b0);
    send_item(OP_VOXEL, 24'h000000, 1'b1);
    send_item(OP_VOXEL, 24'hFFFFFF, 1'b1);
    send_item(OP_VOXEL, 24'h5A5A5A, 1'b0);
    send_item(OP_VOXEL, 24'h000000, 1'b0);
    send_item(OP_VOXEL, 24'hA5A5A5, 1'b1);
    send_item(OP_VOXEL, 24'h000000, 1'b1);
    send_item(OP_VOXEL, 24'hFFFFFF, 1'b0);
    send_item(OP_VOXEL, 24'hFFFFFE, 1'b1);
    send_item(OP_VOXEL, 24'h000001, 1'b0);
    send_item(OP_VOXEL, 24'h000000, 1'b1);
    send_item(OP_VOXEL, 24'hFFFFFF, 1'b1);
    // excess voxel acts as a drain
    send_item(OP_VOXEL, 24'hFFFFFF, 1'b1);
    while (voxels_in != 0) send_item(OP_DRAIN, 24'd0, 1'b0);
    settle();
    // mask on, equal labels
    write_reg(REG_USE_MASK, 24'd1);
    write_reg(REG_LABEL_A, 24'h000005);
    write_reg(REG_LABEL_B, 24'h000005);
    set_volume(8'd2, 8'd2, 11'd1);
    send_item(OP_VOXEL, 24'h000005, 1'b1);
    send_item(OP_VOXEL, 24'h000005, 1'b0);
    send_item(OP_VOXEL, 24'h000007, 1'b1);
    send_item(OP_VOXEL, 24'h000005, 1'b1);
    while (voxels_in != 0) send_item(OP_DRAIN, 24'd0, 1'b0);
    settle();
  endtask

  task automatic test_label_change();
    write_reg(REG_USE_MASK, 24'd0);
    write_reg(REG_LABEL_A, 24'h123456);
    write_reg(REG_LABEL_B, 24'h654321);
    set_volume(8'd4, 8'd3, 11'd2);
    for (int i = 0; i < 12; i++) send_item(OP_VOXEL, pick_label(), 1'($urandom()));
    settle();
    // stored voxels keep their old compare results
    write_reg(REG_LABEL_A, 24'h654321);
    write_reg(REG_LABEL_B, 24'h123456);
    for (int i = 0; i < 12; i++) send_item(OP_VOXEL, pick_label(), 1'($urandom()));
    while (voxels_in != 0) send_item(OP_DRAIN, 24'd0, 1'b0);
    settle();
  endtask

  task automatic test_clamping();
    set_volume(8'd0, 8'd200, 11'd0);     // 1 x 128 x 1
    stream_volume(5);
    settle();
    set_volume(8'd0, 8'd1, 11'd2047);    // 1 x 1 x 1024, leading part only
    for (int i = 0; i < 30; i++) send_item(OP_VOXEL, pick_label(), 1'($urandom()));
    settle();
  endtask

  task automatic test_backpressure();
    rx_mode = 0;
    set_volume(8'd4, 8'd4, 11'd3);
    hold_cnt = 120;
    stream_volume(0);
    settle();
    rx_mode = 1;
  endtask

  task automatic test_random();
    int target;
    target = items_sent + 100;
    while (items_sent < target) begin
      rx_mode = $urandom_range(0, 2);
      write_reg(REG_USE_MASK, 24'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) write_reg(REG_LABEL_A, 24'($urandom()));
      if ($urandom_range(0, 1)) write_reg(REG_LABEL_B, 24'($urandom()));
      set_volume(8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                 11'($urandom_range(0, 3)));
      stream_volume(10);
      settle();
    end
  endtask

  // receiver ready pattern
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      m_axis_tready = 1'b0;
      hold_cnt--;
    end else begin
      case (rx_mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = 1'($urandom_range(0, 1));
        default: m_axis_tready = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    contact_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer, voxel_index %0d", m_axis_tdata[23:0]);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("voxel_index", e.idx, m_axis_tdata[23:0]);
        check_field("in_body_a", e.a, m_axis_tdata[24]);
        check_field("in_body_b", e.b, m_axis_tdata[25]);
        check_field("contact_a", e.ca, m_axis_tdata[26]);
        check_field("contact_b", e.cb, m_axis_tdata[27]);
        check_field("last_voxel", e.last, m_axis_tlast);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    rx_mode = 1;
    test_directed();
    test_label_change();
    test_clamping();
    test_backpressure();
    test_random();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule
